// ----- hdl/timer_event_table_macros.svh -----
// assertion macros for the timer event table
`ifndef TIMER_EVENT_TABLE_MACROS_SVH
`define TIMER_EVENT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define TET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tet check failed");
`define TET_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("tet check failed");
`else
`define TET_ASSERT(lbl, clk, rst, prop)
`define TET_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- hdl/tet_pkg.sv -----
// shared types and constants of the timer event table
package tet_pkg;
   localparam int MAX_EVENTS_DEF = 16;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] KIND_FIRED  = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_ADD    = 2'd2;
   localparam logic [1:0] KIND_REMOVE = 2'd3;

   typedef struct packed {
      logic        active;
      logic        rep;
      logic [31:0] due;
      logic [31:0] ivl;
      logic [31:0] id;
      logic [7:0]  tag;
   } slot_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now;
      logic [31:0] rid;
      logic        placed;
      slot_type    new_slot;
   } ctl_type;

   typedef struct packed {
      logic fire;
      logic place;
   } stat_type;
endpackage

// ----- hdl/tet_cell.sv -----
// one slot of the event ring, with the head processing
module tet_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              process_en,
   input  tet_pkg::ctl_type  ctl,
   input  tet_pkg::slot_type slot_in,
   output tet_pkg::slot_type slot_out,
   output tet_pkg::stat_type stat
);
   import tet_pkg::*;

   slot_type slot_ff;
   logic     hit;

   always_comb begin
      stat.fire  = process_en && (ctl.op == OP_TICK) && slot_ff.active &&
                   (slot_ff.due <= ctl.now);
      stat.place = process_en && (ctl.op == OP_ADD) && !ctl.placed && !slot_ff.active;
      hit        = process_en && (ctl.op == OP_REMOVE) && (slot_ff.id == ctl.rid);
      slot_out   = slot_ff;
      if (stat.fire) begin
         if (slot_ff.rep) begin
            slot_out.due = slot_ff.due + slot_ff.ivl;
         end else begin
            slot_out.active = 1'b0;
         end
      end
      if (stat.place) begin
         slot_out = ctl.new_slot;
      end
      if (hit) begin
         slot_out.active = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.active <= 1'b0;
      end else if (shift_en) begin
         slot_ff <= slot_in;
      end
   end
endmodule

// ----- hdl/timer_event_table.sv -----
// top level of the timer event table: ring of slot cells and request sequencer
// a tick, add or remove scans every slot in ST_SCAN, then loads its last result in ST_FINISH
// a new request is taken only in ST_IDLE, after the last one has turned the full slot ring
// a fired event that meets a stalled result port holds the ring until the result register frees
// reset: synchronous, clears counters, active bits and handshake state
// slot payload is not reset; a remove may compare a free slot's stale id, which is harmless
module timer_event_table #(
   parameter int MAX_EVENTS = tet_pkg::MAX_EVENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_due_tick,
   input  logic [31:0] req_interval,
   input  logic        req_repeat_req,
   input  logic [7:0]  req_handler_tag,
   input  logic [31:0] req_remove_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_event_id,
   output logic [7:0]  rsp_fired_tag,
   output logic [31:0] rsp_tick_count,
   output logic        rsp_overflow,
   output logic        rsp_last
);
   import tet_pkg::*;
`include "timer_event_table_macros.svh"

   localparam int CW = $clog2(MAX_EVENTS + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(MAX_EVENTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] tick_counter_ff, tick_counter_in;
   logic [31:0] id_counter_ff, id_counter_in;
   logic        placed_ff, placed_in;
   op_type      op_ff;
   logic [31:0] due_ff, ivl_ff, rid_ff;
   logic        rep_ff;
   logic [7:0]  tag_ff;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [31:0] id_ff, cnt_out_ff;
   logic [7:0]  ftag_ff;
   logic        ovf_ff, last_ff;

   ctl_type     ctl;
   slot_type    proc_slot [MAX_EVENTS];
   stat_type    stat [MAX_EVENTS];
   logic        fire_any, place_any, shift_en, out_free, ovf;
   logic [31:0] next_tick;

   // cell 0 is the head: it handles the slot now passing it, the rest just rotate
   for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_EVENTS;
      tet_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .process_en (i == 0),
         .ctl        (ctl),
         .slot_in    (proc_slot[NXT]),
         .slot_out   (proc_slot[i]),
         .stat       (stat[i])
      );
   end

   always_comb begin
      fire_any  = 1'b0;
      place_any = 1'b0;
      for (int i = 0; i < MAX_EVENTS; i++) begin
         fire_any  = fire_any | stat[i].fire;
         place_any = place_any | stat[i].place;
      end
   end

   assign ovf       = (tick_counter_ff == 32'hFFFF_FFFF);
   assign next_tick = ovf ? tick_counter_ff : tick_counter_ff + 32'd1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // ring holds while a fired event waits for room in the result register
   assign shift_en  = (state_ff == ST_SCAN) && (!fire_any || out_free);

   always_comb begin
      ctl.op       = op_ff;
      ctl.now      = tick_counter_ff;
      ctl.rid      = rid_ff;
      ctl.placed   = placed_ff;
      ctl.new_slot = '{active: 1'b1, rep: rep_ff, due: due_ff, ivl: ivl_ff,
                       id: id_counter_ff, tag: tag_ff};
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      tick_counter_in = tick_counter_ff;
      id_counter_in   = id_counter_ff;
      placed_in       = placed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (op_type'(req_type) != OP_NONE)) begin
               state_in  = ST_SCAN;
               cnt_in    = '0;
               placed_in = 1'b0;
               if (op_type'(req_type) == OP_ADD) begin
                  id_counter_in = id_counter_ff + 32'd1;
               end
            end
         end
         ST_SCAN: begin
            if (shift_en) begin
               if (place_any) begin
                  placed_in = 1'b1;
               end
               if (cnt_ff == LAST_STEP) begin
                  state_in = ST_FINISH;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (op_ff == OP_TICK) begin
                  tick_counter_in = next_tick;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         tick_counter_ff <= '0;
         id_counter_ff   <= '0;
         placed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         tick_counter_ff <= tick_counter_in;
         id_counter_ff   <= id_counter_in;
         placed_ff       <= placed_in;
         if (shift_en && fire_any) begin
            rsp_valid_ff <= 1'b1;
         end else if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // head slot fields after its update; id and tag never change on a fire
   function automatic logic [31:0] proc_id_head();
      return proc_slot[0].id;
   endfunction

   function automatic logic [7:0] head_tag();
      return proc_slot[0].tag;
   endfunction

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= op_type'(req_type);
         due_ff <= req_due_tick;
         ivl_ff <= req_interval;
         rep_ff <= req_repeat_req;
         tag_ff <= req_handler_tag;
         rid_ff <= req_remove_id;
      end
      if (shift_en && fire_any) begin
         kind_ff    <= KIND_FIRED;
         id_ff      <= proc_id_head();
         ftag_ff    <= head_tag();
         cnt_out_ff <= next_tick;
         ovf_ff     <= 1'b0;
         last_ff    <= 1'b0;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         ftag_ff <= '0;
         last_ff <= 1'b1;
         unique case (op_ff)
            OP_TICK: begin
               kind_ff    <= KIND_TICK;
               id_ff      <= '0;
               cnt_out_ff <= next_tick;
               ovf_ff     <= ovf;
            end
            OP_ADD: begin
               kind_ff    <= KIND_ADD;
               id_ff      <= placed_ff ? id_counter_ff : 32'd0;
               cnt_out_ff <= tick_counter_ff;
               ovf_ff     <= 1'b0;
            end
            default: begin
               kind_ff    <= KIND_REMOVE;
               id_ff      <= '0;
               cnt_out_ff <= tick_counter_ff;
               ovf_ff     <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_event_id   = id_ff;
   assign rsp_fired_tag  = ftag_ff;
   assign rsp_tick_count = cnt_out_ff;
   assign rsp_overflow   = ovf_ff;
   assign rsp_last       = last_ff;

   `TET_ASSERT(a_accept_scan, clock, reset, (req_valid && req_ready && (req_type != OP_NONE)) |=> (state_ff == ST_SCAN))
   `TET_NEVER(a_idle_cnt, clock, reset, (state_ff == ST_IDLE) && (cnt_ff != '0))
   `TET_ASSERT(a_scan_count_hold, clock, reset, (state_ff == ST_SCAN) |=> (tick_counter_ff == $past(tick_counter_ff)))
endmodule

// ----- bench/tb.sv -----
// testbench for timer_event_table: directed table, then random traffic against a predictor
`timescale 1ns / 1ps
module tb;
   import tet_pkg::*;

   localparam int SLOTS      = 16;
   localparam int LATENCY    = SLOTS + 2;
   localparam int WATCH_MAX  = 4000;
   localparam int RAND_ITEMS = 480;

   // one result transfer as seen on the rsp_ port
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] id;
      logic [7:0]  tag;
      logic [31:0] cnt;
      logic        ovf;
      logic        last;
   } rsp_rec;

   // one row of the directed table; typed rows carry their own single expected result
   typedef struct {
      op_type      op;
      logic [31:0] due;
      logic [31:0] ivl;
      logic        rep;
      logic [7:0]  tag;
      logic [31:0] rid;
      bit          typed;
      logic [1:0]  exp_kind;
      logic [31:0] exp_id;
      logic [31:0] exp_cnt;
   } stim_row;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [31:0] req_due_tick;
   logic [31:0] req_interval;
   logic        req_repeat_req;
   logic [7:0]  req_handler_tag;
   logic [31:0] req_remove_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_event_id;
   logic [7:0]  rsp_fired_tag;
   logic [31:0] rsp_tick_count;
   logic        rsp_overflow;
   logic        rsp_last;

   timer_event_table dut (.*);

   // predictor copy of the table
   logic [31:0] ticks_now;
   logic [31:0] ids_issued;
   int          slots_used;
   logic        tbl_active [SLOTS];
   logic        tbl_rep    [SLOTS];
   logic [31:0] tbl_due    [SLOTS];
   logic [31:0] tbl_ivl    [SLOTS];
   logic [31:0] tbl_id     [SLOTS];
   logic [7:0]  tbl_tag    [SLOTS];

   rsp_rec pending_rsp[$];
   bit     failed;
   int     send_idle;
   int     recv_idle;
   int     hold_off;
   int     quiet_cycles;
   bit     typed_now;
   rsp_rec typed_rsp;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // advance the table by one accepted request and queue what it must answer
   function automatic void timer_table_step(logic [1:0] op, logic [31:0] due, logic [31:0] ivl,
                                            logic rep, logic [7:0] tag, logic [31:0] rid);
      logic [31:0] nxt;
      logic        ovf;
      int          pick;
      if (op == OP_TICK) begin
         ovf = (ticks_now == 32'hFFFF_FFFF);
         nxt = ovf ? ticks_now : ticks_now + 32'd1;
         for (int i = 0; i < slots_used; i++) begin
            if (tbl_active[i] && tbl_due[i] <= ticks_now) begin
               pending_rsp.push_back('{KIND_FIRED, tbl_id[i], tbl_tag[i], nxt, 1'b0, 1'b0});
               if (tbl_rep[i]) tbl_due[i] = tbl_due[i] + tbl_ivl[i];
               else tbl_active[i] = 1'b0;
            end
         end
         ticks_now = nxt;
         pending_rsp.push_back('{KIND_TICK, 32'd0, 8'd0, nxt, ovf, 1'b1});
      end else if (op == OP_ADD) begin
         ids_issued = ids_issued + 32'd1;
         pick = -1;
         for (int i = 0; i < slots_used; i++) begin
            if (!tbl_active[i] && pick < 0) pick = i;
         end
         if (pick < 0 && slots_used < SLOTS) begin
            pick = slots_used;
            slots_used++;
         end
         if (pick >= 0) begin
            tbl_active[pick] = 1'b1;
            tbl_rep[pick]    = rep;
            tbl_due[pick]    = due;
            tbl_ivl[pick]    = ivl;
            tbl_id[pick]     = ids_issued;
            tbl_tag[pick]    = tag;
         end
         pending_rsp.push_back('{KIND_ADD, (pick >= 0) ? ids_issued : 32'd0, 8'd0,
                                 ticks_now, 1'b0, 1'b1});
      end else if (op == OP_REMOVE) begin
         for (int i = 0; i < slots_used; i++) begin
            if (tbl_id[i] == rid) tbl_active[i] = 1'b0;
         end
         pending_rsp.push_back('{KIND_REMOVE, 32'd0, 8'd0, ticks_now, 1'b0, 1'b1});
      end
   endfunction

   // request side monitor: predict on every accepted transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (typed_now) begin
            // the hand-typed answer stands in for the predicted one
            timer_table_step(req_type, req_due_tick, req_interval, req_repeat_req,
                             req_handler_tag, req_remove_id);
            void'(pending_rsp.pop_back());
            pending_rsp.push_back(typed_rsp);
         end else begin
            timer_table_step(req_type, req_due_tick, req_interval, req_repeat_req,
                             req_handler_tag, req_remove_id);
         end
      end
   end

   // result side checker
   always @(posedge clock) begin
      rsp_rec got;
      rsp_rec want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_event_id, rsp_fired_tag, rsp_tick_count, rsp_overflow, rsp_last};
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result transfer, actual %h", $time, got);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready = 1'b0;
         hold_off--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // present one request from the falling edge until it is accepted
   task automatic send(logic [1:0] op, logic [31:0] due, logic [31:0] ivl, logic rep,
                       logic [7:0] tag, logic [31:0] rid);
      @(negedge clock);
      req_valid       = 1'b1;
      req_type        = op;
      req_due_tick    = due;
      req_interval    = ivl;
      req_repeat_req  = rep;
      req_handler_tag = tag;
      req_remove_id   = rid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(0, 99) < send_idle) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   // let the block drain, then the latency margin
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      typed_now = 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random request: mostly near-term events and removes of live ids, some noise
   task automatic random_item(output bit counted);
      int          r;
      logic [31:0] due;
      logic [31:0] ivl;
      logic [31:0] rid;
      r   = $urandom_range(0, 99);
      due = ($urandom_range(0, 9) < 8) ? ticks_now + $urandom_range(0, 6) : $urandom;
      ivl = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom;
      rid = ($urandom_range(0, 9) < 7) ? ids_issued - $urandom_range(0, 20) : $urandom;
      counted = 1'b1;
      if (r < 35) send(OP_TICK, $urandom, $urandom, 1'($urandom), 8'($urandom), $urandom);
      else if (r < 75) send(OP_ADD, due, ivl, 1'($urandom), 8'($urandom), $urandom);
      else if (r < 95) send(OP_REMOVE, $urandom, $urandom, 1'($urandom), 8'($urandom), rid);
      else begin
         send(OP_NONE, $urandom, $urandom, 1'($urandom), 8'($urandom), $urandom);
         counted = 1'b0;
      end
   endtask

   stim_row rows [15];

   initial begin
      bit counted;
      int done_items;
      failed       = 1'b0;
      hold_off     = 0;
      quiet_cycles = 0;
      typed_now    = 1'b0;
      ticks_now    = '0;
      ids_issued   = '0;
      slots_used   = 0;
      for (int i = 0; i < SLOTS; i++) tbl_active[i] = 1'b0;
      send_idle       = 9;
      recv_idle       = 46;
      reset           = 1'b1;
      req_valid       = 1'b0;
      rsp_ready       = 1'b0;
      req_type        = OP_TICK;
      req_due_tick    = '0;
      req_interval    = '0;
      req_repeat_req  = 1'b0;
      req_handler_tag = '0;
      req_remove_id   = '0;

      // directed rows: empty tick, field extremes, wrap of a repeating due tick,
      // remove of unknown id, ignored request type, reuse of a freed slot
      rows[0]  = '{OP_TICK,   0, 0, 0, 0, 0, 1, KIND_TICK, 0, 1};
      rows[1]  = '{OP_ADD,    0, 0, 1, 8'hFF, 0, 1, KIND_ADD, 1, 1};
      rows[2]  = '{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 8'h00, 0, 1, KIND_ADD, 2, 1};
      rows[3]  = '{OP_ADD,    1, 32'hFFFF_FFFF, 1, 8'h5A, 0, 1, KIND_ADD, 3, 1};
      rows[4]  = '{OP_ADD,    2, 3, 0, 8'hA5, 0, 1, KIND_ADD, 4, 1};
      rows[5]  = '{OP_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0};
      rows[6]  = '{OP_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0};
      rows[7]  = '{OP_REMOVE, 0, 0, 0, 0, 2, 1, KIND_REMOVE, 0, 3};
      rows[8]  = '{OP_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, KIND_REMOVE, 0, 3};
      rows[9]  = '{OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 8'hFF, 32'hFFFF_FFFF,
                   0, 0, 0, 0};
      rows[10] = '{OP_ADD,    0, 1, 0, 8'h3C, 0, 0, 0, 0, 0};
      rows[11] = '{OP_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0};
      rows[12] = '{OP_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0};
      rows[13] = '{OP_REMOVE, 0, 0, 0, 0, 1, 0, 0, 0, 0};
      rows[14] = '{OP_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         @(negedge clock);
         // drop valid so an accepted row is not offered again while the flag changes
         req_valid = 1'b0;
         typed_now = rows[i].typed;
         typed_rsp = '{rows[i].exp_kind, rows[i].exp_id, 8'd0, rows[i].exp_cnt, 1'b0, 1'b1};
         send(rows[i].op, rows[i].due, rows[i].ivl, rows[i].rep, rows[i].tag, rows[i].rid);
      end
      drain();

      // long receiver hold-off while requests keep coming: result side fills, input stalls
      hold_off   = 300;
      done_items = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 9 : (ph == 1) ? 46 : 0;
         recv_idle = (ph == 0) ? 46 : (ph == 1) ? 9 : 0;
         for (int n = 0; n < RAND_ITEMS / 3; ) begin
            random_item(counted);
            if (counted) n++;
         end
         // sender pauses until every expected result is back
         drain();
      end

      if (!failed) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
